[sv/pxansi_pkg.sv]
`timescale 1ns / 1ps

package pxansi_pkg;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_8    = 8'h38;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_NL   = 8'h0A;

  // Decimal digits of red, green and blue (index 0, 1, 2), palette index and flags.
  typedef struct packed {
    logic [2:0][1:0] hund;
    logic [2:0][3:0] tens;
    logic [2:0][3:0] units;
    logic [3:0]      pal_idx;
    logic            frame_start;
    logic            row_end;
    logic            frame_end;
  } job_t;

endpackage

[sv/pxansi_front.sv]
`timescale 1ns / 1ps

module pxansi_front (
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic [7:0]       brightness,
  input  logic             frame_start,
  input  logic             row_end,
  input  logic             frame_end,
  output pxansi_pkg::job_t job
);

  function automatic logic [9:0] dec_split(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  base;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [3:0]  u;
    h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    base = (h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0);
    rem  = 7'(v - base);
    prod = 15'(rem) * 15'd205;
    t    = prod[14:11];
    u    = 4'(rem - 7'(t) * 7'd10);
    return {h, t, u};
  endfunction

  logic [9:0]  dr, dg, db;
  logic [11:0] y9;
  logic [3:0]  idx;

  always_comb begin
    dr = dec_split(red);
    dg = dec_split(green);
    db = dec_split(blue);
    y9 = 12'(brightness) * 12'd9;
    idx = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (y9 >= 12'(255 * k)) begin
        idx = idx + 4'd1;
      end
    end
    job.hund[0]     = dr[9:8];
    job.tens[0]     = dr[7:4];
    job.units[0]    = dr[3:0];
    job.hund[1]     = dg[9:8];
    job.tens[1]     = dg[7:4];
    job.units[1]    = dg[3:0];
    job.hund[2]     = db[9:8];
    job.tens[2]     = db[7:4];
    job.units[2]    = db[3:0];
    job.pal_idx     = idx;
    job.frame_start = frame_start;
    job.row_end     = row_end;
    job.frame_end   = frame_end;
  end

endmodule

[sv/pxansi_queue.sv]
`timescale 1ns / 1ps

module pxansi_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  pxansi_pkg::job_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output pxansi_pkg::job_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pxansi_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_cnt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr) |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("queue count did not drop on read");

endmodule

[sv/pxansi_back.sv]
`timescale 1ns / 1ps

module pxansi_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  pxansi_pkg::job_t q_job,
  output logic             q_pop,
  output logic [7:0]       out_byte,
  output logic             out_last_byte,
  output logic             empty,
  input  logic             pop
);

  typedef enum logic [4:0] {
    S_HOME_ESC, S_HOME_BR, S_HOME_H,
    S_SGR_ESC, S_SGR_BR, S_SGR_3, S_SGR_8, S_SGR_SEMI0, S_SGR_2, S_SGR_SEMI1,
    S_COL_H, S_COL_T, S_COL_U, S_COL_SEP,
    S_PAL, S_NL,
    S_RST_ESC, S_RST_BR, S_RST_0, S_RST_M
  } state_t;

  function automatic logic [7:0] pal_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h20;
      4'd1:    c = 8'h2E;
      4'd2:    c = 8'h3A;
      4'd3:    c = 8'h2D;
      4'd4:    c = 8'h3D;
      4'd5:    c = 8'h2B;
      4'd6:    c = 8'h2A;
      4'd7:    c = 8'h23;
      4'd8:    c = 8'h25;
      default: c = 8'h40;
    endcase
    return c;
  endfunction

  function automatic state_t first_digit(input logic [1:0] h, input logic [3:0] t);
    state_t s;
    if (h != 2'd0) begin
      s = S_COL_H;
    end else if (t != 4'd0) begin
      s = S_COL_T;
    end else begin
      s = S_COL_U;
    end
    return s;
  endfunction

  pxansi_pkg::job_t job_r;
  state_t           st_r, st_nxt, st_first;
  logic [1:0]       col_r, col_nxt;
  logic             busy_r;
  logic             ov_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             adv;
  logic             done;
  logic [7:0]       byte_nxt;
  logic [1:0]       cur_h, nx_h;
  logic [3:0]       cur_t, cur_u, nx_t;

  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;
  assign empty         = !ov_r;
  assign adv           = !ov_r || pop;
  assign q_pop         = adv && q_valid && (!busy_r || done);
  assign st_first      = q_job.frame_start ? S_HOME_ESC : S_SGR_ESC;

  always_comb begin
    case (col_r)
      2'd0: begin
        cur_h = job_r.hund[0];  cur_t = job_r.tens[0];  cur_u = job_r.units[0];
        nx_h  = job_r.hund[1];  nx_t  = job_r.tens[1];
      end
      2'd1: begin
        cur_h = job_r.hund[1];  cur_t = job_r.tens[1];  cur_u = job_r.units[1];
        nx_h  = job_r.hund[2];  nx_t  = job_r.tens[2];
      end
      default: begin
        cur_h = job_r.hund[2];  cur_t = job_r.tens[2];  cur_u = job_r.units[2];
        nx_h  = job_r.hund[2];  nx_t  = job_r.tens[2];
      end
    endcase
  end

  always_comb begin
    byte_nxt = pxansi_pkg::CH_ESC;
    st_nxt   = st_r;
    col_nxt  = col_r;
    done     = 1'b0;
    case (st_r)
      S_HOME_ESC:  begin byte_nxt = pxansi_pkg::CH_ESC;  st_nxt = S_HOME_BR;   end
      S_HOME_BR:   begin byte_nxt = pxansi_pkg::CH_LBR;  st_nxt = S_HOME_H;    end
      S_HOME_H:    begin byte_nxt = pxansi_pkg::CH_H;    st_nxt = S_SGR_ESC;   end
      S_SGR_ESC:   begin byte_nxt = pxansi_pkg::CH_ESC;  st_nxt = S_SGR_BR;    end
      S_SGR_BR:    begin byte_nxt = pxansi_pkg::CH_LBR;  st_nxt = S_SGR_3;     end
      S_SGR_3:     begin byte_nxt = pxansi_pkg::CH_3;    st_nxt = S_SGR_8;     end
      S_SGR_8:     begin byte_nxt = pxansi_pkg::CH_8;    st_nxt = S_SGR_SEMI0; end
      S_SGR_SEMI0: begin byte_nxt = pxansi_pkg::CH_SEMI; st_nxt = S_SGR_2;     end
      S_SGR_2:     begin byte_nxt = pxansi_pkg::CH_2;    st_nxt = S_SGR_SEMI1; end
      S_SGR_SEMI1: begin
        byte_nxt = pxansi_pkg::CH_SEMI;
        st_nxt   = first_digit(job_r.hund[0], job_r.tens[0]);
        col_nxt  = 2'd0;
      end
      S_COL_H: begin
        byte_nxt = pxansi_pkg::CH_0 + {6'd0, cur_h};
        st_nxt   = S_COL_T;
      end
      S_COL_T: begin
        byte_nxt = pxansi_pkg::CH_0 + {4'd0, cur_t};
        st_nxt   = S_COL_U;
      end
      S_COL_U: begin
        byte_nxt = pxansi_pkg::CH_0 + {4'd0, cur_u};
        st_nxt   = S_COL_SEP;
      end
      S_COL_SEP: begin
        if (col_r == 2'd2) begin
          byte_nxt = pxansi_pkg::CH_M;
          st_nxt   = S_PAL;
        end else begin
          byte_nxt = pxansi_pkg::CH_SEMI;
          st_nxt   = first_digit(nx_h, nx_t);
          col_nxt  = col_r + 2'd1;
        end
      end
      S_PAL: begin
        byte_nxt = pal_char(job_r.pal_idx);
        if (job_r.row_end) begin
          st_nxt = S_NL;
        end else if (job_r.frame_end) begin
          st_nxt = S_RST_ESC;
        end else begin
          done = 1'b1;
        end
      end
      S_NL: begin
        byte_nxt = pxansi_pkg::CH_NL;
        if (job_r.frame_end) begin
          st_nxt = S_RST_ESC;
        end else begin
          done = 1'b1;
        end
      end
      S_RST_ESC: begin byte_nxt = pxansi_pkg::CH_ESC; st_nxt = S_RST_BR; end
      S_RST_BR:  begin byte_nxt = pxansi_pkg::CH_LBR; st_nxt = S_RST_0;  end
      S_RST_0:   begin byte_nxt = pxansi_pkg::CH_0;   st_nxt = S_RST_M;  end
      S_RST_M:   begin byte_nxt = pxansi_pkg::CH_M;   done = 1'b1;       end
      default: begin
        byte_nxt = pxansi_pkg::CH_ESC;
        done     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      st_r   <= S_SGR_ESC;
      col_r  <= 2'd0;
    end else if (adv) begin
      if (busy_r) begin
        ov_r       <= 1'b1;
        out_byte_r <= byte_nxt;
        out_last_r <= done;
        if (done) begin
          if (q_valid) begin
            job_r <= q_job;
            st_r  <= st_first;
            col_r <= 2'd0;
          end else begin
            busy_r <= 1'b0;
          end
        end else begin
          st_r  <= st_nxt;
          col_r <= col_nxt;
        end
      end else begin
        ov_r <= 1'b0;
        if (q_valid) begin
          busy_r <= 1'b1;
          job_r  <= q_job;
          st_r   <= st_first;
          col_r  <= 2'd0;
        end
      end
    end
  end

  a_next_is_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && pop && out_last_r) |=> (!ov_r || out_byte_r == pxansi_pkg::CH_ESC))
    else $error("byte after a final byte is not an escape");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> col_r != 2'd3)
    else $error("color select out of range");

endmodule

[sv/pixel_to_ansi_truecolor_text_unit.sv]
`timescale 1ns / 1ps

// Pixel to terminal text encoder. Each pixel pushed in becomes 14 to 28 bytes of an
// ANSI truecolor text stream: an optional cursor home, the 38;2 color sequence with
// red, green and blue in decimal, the palette character picked by brightness, an
// optional newline and an optional color reset; the final byte of a pixel is flagged
// on out_last_byte. The byte sequencer in the back end emits one byte per clock while
// the output is not stalled, and it loads the next queued pixel when it emits the
// final byte of the current one. Classification is combinational into a queue of
// DEPTH pixels, so DEPTH pixels can wait behind the one being sequenced while the
// sequencer or the output stalls; a pixel pushed into an idle block goes into the
// queue, then into the job register, and then its first byte into out_byte.
module pixel_to_ansi_truecolor_text_unit #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_brightness,
  input  logic       in_frame_start,
  input  logic       in_row_end,
  input  logic       in_frame_end,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic       out_last_byte,
  output logic       empty,
  input  logic       pop
);

  pxansi_pkg::job_t fr_job, q_job;
  logic             q_valid, q_pop;

  pxansi_front u_front (
    .red         (in_red),
    .green       (in_green),
    .blue        (in_blue),
    .brightness  (in_brightness),
    .frame_start (in_frame_start),
    .row_end     (in_row_end),
    .frame_end   (in_frame_end),
    .job         (fr_job)
  );

  pxansi_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (fr_job),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_job)
  );

  pxansi_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_job         (q_job),
    .q_pop         (q_pop),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .empty         (empty),
    .pop           (pop)
  );

endmodule
